// ===== rtl/core/spwpl_pkg.sv =====
// Shared types and constants of the single-pass window pixel labeler.
`default_nettype none
package spwpl_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned RAD_W      = 2;
  localparam int unsigned LABEL_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FG_IS_WHITE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT  = 3'd4;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [LABEL_W-1:0] LABEL_MAX = 8'd254;

  typedef struct packed {
    logic cmd;
    logic frame_start;
    logic pixel_bit;
  } in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] pixel_label;
    logic [LABEL_W-1:0] segment_count;
    logic               frame_last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CWAIT,
    S_SCAN,
    S_SWAIT,
    S_DECIDE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic take;
    logic ctr_read;
    logic scan_init;
    logic scan_step;
    logic mark_any;
    logic set_label;
    logic set_new;
    logic set_zero;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic center_fg;
    logic nb_skip;
    logic scan_last;
    logic nb_hit;
    logic any;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/spwpl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module spwpl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/spwpl_ctrl.sv =====
// Controller state machine: sequences intake, window scan and result hand-off.
`default_nettype none
module spwpl_ctrl import spwpl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = sts.emit_ok ? S_CWAIT : S_IDLE;
      S_CWAIT:  state_nxt = sts.center_fg ? S_SCAN : S_FIN;
      S_SCAN: begin
        if (!sts.nb_skip) begin
          state_nxt = S_SWAIT;
        end else if (sts.scan_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_SWAIT: begin
        if (sts.nb_hit) begin
          state_nxt = S_FIN;
        end else if (sts.scan_last) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_DECIDE: state_nxt = S_FIN;
      S_FIN:    if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_CHECK:  cmd.ctr_read = sts.emit_ok;
      S_CWAIT: begin
        cmd.scan_init = sts.center_fg;
        cmd.set_zero  = !sts.center_fg;
      end
      S_SCAN:   cmd.scan_step = sts.nb_skip;
      S_SWAIT: begin
        cmd.set_label = sts.nb_hit;
        cmd.scan_step = !sts.nb_hit;
        cmd.mark_any  = !sts.nb_hit;
      end
      S_DECIDE: begin
        cmd.set_new  = sts.any;
        cmd.set_zero = !sts.any;
      end
      S_FIN:    cmd.finish = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/spwpl_dp.sv =====
// Datapath: configuration, history RAMs, frame counters, window walk and output register.
`default_nettype none
module spwpl_dp import spwpl_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_RADIUS = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_t                   in_data,
  output out_t                       out_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire ctrl_cmd_t             cmd,
  output ctrl_sts_t                  sts
);

  localparam int unsigned PIX_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int unsigned LAB_DEPTH = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
  localparam int unsigned W_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned R_W   = $clog2(MAX_RADIUS + 1);
  localparam int unsigned IJ_W  = R_W + 1;
  localparam int unsigned CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned PA_W  = $clog2(PIX_DEPTH);
  localparam int unsigned LA_W  = $clog2(LAB_DEPTH);
  localparam int unsigned OFF_W = PA_W + 2;
  localparam int unsigned C_W   = ((W_W > H_W) ? W_W : H_W) + 2;

  logic [DIM_W-1:0]   cfg_width_r, cfg_height_r;
  logic [RAD_W-1:0]   cfg_radius_r;
  logic               cfg_fg_r;
  logic [LABEL_W-1:0] cfg_limit_r;

  logic [W_W-1:0]   w_c;
  logic [H_W-1:0]   h_c;
  logic [R_W-1:0]   r_c;
  logic [CNT_W-1:0] d_c, total_c;

  logic [CNT_W-1:0]   recv_r, recv_nxt, emit_r, emit_nxt;
  logic [PA_W-1:0]    recv_ptr_r, recv_ptr_nxt, ppix_r, ppix_nxt;
  logic [LA_W-1:0]    plab_r, plab_nxt;
  logic [W_W-1:0]     ex_r, ex_nxt;
  logic [H_W-1:0]     ey_r, ey_nxt;
  logic [LABEL_W-1:0] lcnt_r, lcnt_nxt, lcnt_inc;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic signed [IJ_W-1:0] i_r, i_nxt, j_r, j_nxt, rs;
  logic               any_r, any_nxt, new_r, new_nxt;
  logic [LABEL_W-1:0] lbl_r, lbl_nxt, label_val;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  logic [CNT_W-1:0]   recv_b;
  logic [PA_W-1:0]    recv_ptr_b;
  logic               pix_we;
  logic [OFF_W-1:0]   pix_sum, lab_sum, pix_fix, lab_fix;
  logic [PA_W-1:0]    pix_raddr;
  logic [LA_W-1:0]    lab_raddr;
  logic [0:0]         pix_rd;
  logic [LABEL_W-1:0] lab_rd;
  logic signed [C_W-1:0] nx, ny;
  logic               nb_fg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= 11'd640;
      cfg_height_r <= 11'd480;
      cfg_radius_r <= 2'd1;
      cfg_fg_r     <= 1'b1;
      cfg_limit_r  <= 8'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   cfg_width_r  <= cfg_data;
        REG_IMAGE_HEIGHT:  cfg_height_r <= cfg_data;
        REG_WINDOW_RADIUS: cfg_radius_r <= cfg_data[RAD_W-1:0];
        REG_FG_IS_WHITE:   cfg_fg_r     <= cfg_data[0];
        REG_COUNT_LIMIT:   cfg_limit_r  <= cfg_data[LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_r == '0) begin
      w_c = W_W'(1);
    end else if (cfg_width_r > MAX_WIDTH) begin
      w_c = W_W'(MAX_WIDTH);
    end else begin
      w_c = W_W'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_c = H_W'(1);
    end else if (cfg_height_r > MAX_HEIGHT) begin
      h_c = H_W'(MAX_HEIGHT);
    end else begin
      h_c = H_W'(cfg_height_r);
    end
    r_c     = (cfg_radius_r > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(cfg_radius_r);
    d_c     = CNT_W'(r_c) * CNT_W'(w_c) + CNT_W'(r_c);
    total_c = CNT_W'(w_c) * CNT_W'(h_c);
  end

  assign rs = $signed({1'b0, r_c});

  always_comb begin
    pix_sum = OFF_W'(ppix_r) + off_r;
    lab_sum = OFF_W'(plab_r) + off_r;
    if (pix_sum[OFF_W-1]) begin
      pix_fix = pix_sum + OFF_W'(PIX_DEPTH);
    end else if (pix_sum >= OFF_W'(PIX_DEPTH)) begin
      pix_fix = pix_sum - OFF_W'(PIX_DEPTH);
    end else begin
      pix_fix = pix_sum;
    end
    if (lab_sum[OFF_W-1]) begin
      lab_fix = lab_sum + OFF_W'(LAB_DEPTH);
    end else if (lab_sum >= OFF_W'(LAB_DEPTH)) begin
      lab_fix = lab_sum - OFF_W'(LAB_DEPTH);
    end else begin
      lab_fix = lab_sum;
    end
    pix_raddr = cmd.ctr_read ? ppix_r : PA_W'(pix_fix);
    lab_raddr = LA_W'(lab_fix);
  end

  always_comb begin
    recv_b     = in_data.frame_start ? '0 : recv_r;
    recv_ptr_b = in_data.frame_start ? '0 : recv_ptr_r;
    pix_we     = cmd.take && (in_data.cmd == CMD_PIXEL) && (recv_b < total_c);
  end

  spwpl_ram #(.WIDTH(1), .DEPTH(PIX_DEPTH)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (recv_ptr_b),
    .wdata (in_data.pixel_bit),
    .raddr (pix_raddr),
    .rdata (pix_rd)
  );

  spwpl_ram #(.WIDTH(LABEL_W), .DEPTH(LAB_DEPTH)) u_lab_ram (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (plab_r),
    .wdata (label_val),
    .raddr (lab_raddr),
    .rdata (lab_rd)
  );

  always_comb begin
    nx    = C_W'($signed({1'b0, ex_r})) + C_W'(j_r);
    ny    = C_W'($signed({1'b0, ey_r})) + C_W'(i_r);
    nb_fg = (pix_rd[0] == cfg_fg_r);

    sts.emit_ok   = (emit_r < recv_r) && ((recv_r - emit_r > d_c) || (recv_r >= total_c));
    sts.center_fg = nb_fg;
    sts.nb_skip   = ((i_r == '0) && (j_r == '0)) || nx[C_W-1] || ny[C_W-1] ||
                    (nx >= $signed(C_W'(w_c))) || (ny >= $signed(C_W'(h_c)));
    sts.scan_last = (i_r == rs) && (j_r == rs);
    sts.nb_hit    = nb_fg && off_r[OFF_W-1] && (lab_rd != '0);
    sts.any       = any_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    lcnt_inc  = (lcnt_r < LABEL_MAX) ? lcnt_r + 8'd1 : lcnt_r;
    label_val = new_r ? lcnt_inc : lbl_r;

    recv_nxt      = recv_r;
    recv_ptr_nxt  = recv_ptr_r;
    emit_nxt      = emit_r;
    ppix_nxt      = ppix_r;
    plab_nxt      = plab_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    lcnt_nxt      = lcnt_r;
    off_nxt       = off_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    any_nxt       = any_r;
    new_nxt       = new_r;
    lbl_nxt       = lbl_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.take) begin
      recv_nxt     = recv_b;
      recv_ptr_nxt = recv_ptr_b;
      if (in_data.frame_start) begin
        emit_nxt = '0;
        ppix_nxt = '0;
        plab_nxt = '0;
        ex_nxt   = '0;
        ey_nxt   = '0;
        lcnt_nxt = '0;
      end
      if (pix_we) begin
        recv_nxt     = recv_b + CNT_W'(1);
        recv_ptr_nxt = (recv_ptr_b == PA_W'(PIX_DEPTH - 1)) ? '0 : recv_ptr_b + PA_W'(1);
      end
    end

    if (cmd.scan_init) begin
      i_nxt   = -rs;
      j_nxt   = -rs;
      off_nxt = OFF_W'(0) - OFF_W'(d_c);
      any_nxt = 1'b0;
    end

    if (cmd.mark_any && nb_fg) begin
      any_nxt = 1'b1;
    end

    if (cmd.scan_step) begin
      if (j_r == rs) begin
        j_nxt   = -rs;
        i_nxt   = i_r + IJ_W'(1);
        off_nxt = off_r + OFF_W'(w_c) - OFF_W'({r_c, 1'b0});
      end else begin
        j_nxt   = j_r + IJ_W'(1);
        off_nxt = off_r + OFF_W'(1);
      end
    end

    if (cmd.set_label) begin
      lbl_nxt = lab_rd;
      new_nxt = 1'b0;
    end
    if (cmd.set_zero) begin
      lbl_nxt = '0;
      new_nxt = 1'b0;
    end
    if (cmd.set_new) begin
      new_nxt = 1'b1;
    end

    if (cmd.finish) begin
      if (new_r) begin
        lcnt_nxt = lcnt_inc;
      end
      out_nxt.pixel_label   = label_val;
      out_nxt.segment_count = (lcnt_nxt < cfg_limit_r) ? lcnt_nxt : cfg_limit_r;
      out_nxt.frame_last    = (emit_r + CNT_W'(1) == total_c);
      out_valid_nxt         = 1'b1;
      emit_nxt = emit_r + CNT_W'(1);
      ppix_nxt = (ppix_r == PA_W'(PIX_DEPTH - 1)) ? '0 : ppix_r + PA_W'(1);
      plab_nxt = (plab_r == LA_W'(LAB_DEPTH - 1)) ? '0 : plab_r + LA_W'(1);
      if (ex_r + W_W'(1) == w_c) begin
        ex_nxt = '0;
        ey_nxt = ey_r + H_W'(1);
      end else begin
        ex_nxt = ex_r + W_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_r      <= '0;
      recv_ptr_r  <= '0;
      emit_r      <= '0;
      ppix_r      <= '0;
      plab_r      <= '0;
      ex_r        <= '0;
      ey_r        <= '0;
      lcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      recv_r      <= recv_nxt;
      recv_ptr_r  <= recv_ptr_nxt;
      emit_r      <= emit_nxt;
      ppix_r      <= ppix_nxt;
      plab_r      <= plab_nxt;
      ex_r        <= ex_nxt;
      ey_r        <= ey_nxt;
      lcnt_r      <= lcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    any_r <= any_nxt;
    new_r <= new_nxt;
    lbl_r <= lbl_nxt;
    out_r <= out_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/core/single_pass_window_pixel_labeler.sv =====
// Top level of the single-pass window pixel labeler.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_data   (in_t)
//   out_     output     out_valid / out_ready  out_data  (out_t)
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A transaction that releases no label returns to idle after the check; a background
// pixel goes straight to the finish state; otherwise the window walk reads the pixel
// and label history RAMs one neighbor at a time, up to the first labeled neighbor.
// Synchronous active-low reset clears the control state; history RAMs hold no reset.
// A finished label waits in the output register; the next transaction is taken meanwhile.
`default_nettype none
module single_pass_window_pixel_labeler import spwpl_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_RADIUS = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  spwpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spwpl_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire
